@@ rtl/rh_pkg.sv @@
package rh_pkg;

  // datapath width of the cordic x, y and z registers
  localparam int CW = 32;
  localparam int MAX_STAGES = 24;
  localparam int ITER_STAGES_DEF = 16;

  // fixed-point constants
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic signed [30:0] INVPI_Q30 = 31'sd341782638;
  localparam logic [25:0] PI_Q24 = 26'd52707179;
  localparam logic [26:0] LN2_Q24 = 27'd11629080;
  localparam logic signed [CW-1:0] GAIN_Q28 = 32'sd163008219;
  localparam logic [15:0] FUZZ_RESET = 16'd512;

  // divider geometry
  localparam int D1_DIV_W = 16;
  localparam int D1_Q_W = 40;
  localparam int D2_DIV_W = 50;
  localparam int D2_Q_W = 15;

  typedef enum logic [1:0] {
    MODE_ATAN = 2'd0,
    MODE_BIN  = 2'd1,
    MODE_SIG  = 2'd2,
    MODE_SINE = 2'd3
  } mode_t;

  typedef enum logic {
    REG_STEP_MODE = 1'b0,
    REG_FUZZINESS = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_VEC   = 2'd0,
    OP_ROT_C = 2'd1,
    OP_ROT_H = 2'd2
  } cordic_op_t;

  // sideband through the front divider
  typedef struct packed {
    mode_t             mode;
    logic signed [15:0] v;
    logic [15:0]       f;
    logic              fixed;
    logic signed [15:0] fixed_res;
  } front_side_t;

  // sideband through the cordic
  typedef struct packed {
    mode_t             mode;
    logic              neg;
    logic              fixed;
    logic signed [15:0] fixed_res;
    logic [24:0]       r25;
    logic [3:0]        k;
  } cordic_side_t;

  // sideband through the ratio divider
  typedef struct packed {
    logic              use_quot;
    logic              neg;
    logic signed [15:0] res;
  } tail_side_t;

  // circular arctan table, Q24 radians
  function automatic logic signed [CW-1:0] circ_angle(input int i);
    logic signed [CW-1:0] a;
    case (i)
      0: a = 32'sd13176795;
      1: a = 32'sd7778716;
      2: a = 32'sd4110060;
      3: a = 32'sd2086331;
      4: a = 32'sd1047214;
      5: a = 32'sd524117;
      6: a = 32'sd262123;
      7: a = 32'sd131069;
      8: a = 32'sd65536;
      9: a = 32'sd32768;
      10: a = 32'sd16384;
      11: a = 32'sd8192;
      12: a = 32'sd4096;
      13: a = 32'sd2048;
      14: a = 32'sd1024;
      15: a = 32'sd512;
      16: a = 32'sd256;
      17: a = 32'sd128;
      18: a = 32'sd64;
      19: a = 32'sd32;
      20: a = 32'sd16;
      21: a = 32'sd8;
      22: a = 32'sd4;
      default: a = 32'sd2;
    endcase
    return a;
  endfunction

  // hyperbolic artanh table, Q24, indexed by shift
  function automatic logic signed [CW-1:0] hyp_angle(input int i);
    logic signed [CW-1:0] a;
    case (i)
      1: a = 32'sd9215828;
      2: a = 32'sd4285116;
      3: a = 32'sd2108178;
      4: a = 32'sd1049945;
      5: a = 32'sd524459;
      6: a = 32'sd262165;
      7: a = 32'sd131075;
      8: a = 32'sd65536;
      9: a = 32'sd32768;
      10: a = 32'sd16384;
      11: a = 32'sd8192;
      12: a = 32'sd4096;
      13: a = 32'sd2048;
      14: a = 32'sd1024;
      15: a = 32'sd512;
      16: a = 32'sd256;
      17: a = 32'sd128;
      18: a = 32'sd64;
      19: a = 32'sd32;
      20: a = 32'sd16;
      21: a = 32'sd8;
      22: a = 32'sd4;
      23: a = 32'sd2;
      24: a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

  // hyperbolic shift per stage, with shifts 4 and 13 repeated
  function automatic int hyp_shift(input int s);
    int h;
    if (s < 4) h = s + 1;
    else if (s < 14) h = s;
    else h = s - 1;
    return h;
  endfunction

  // saturate to -1..1 in Q2.14
  function automatic logic signed [15:0] clamp_q14(input logic signed [CW-1:0] r);
    logic signed [15:0] c;
    if (r > CW'(ONE_Q14)) c = ONE_Q14;
    else if (r < -CW'(ONE_Q14)) c = -ONE_Q14;
    else c = r[15:0];
    return c;
  endfunction

endpackage

@@ rtl/rh_div.sv @@
module rh_div import rh_pkg::*; #(
  parameter int DIV_W = D1_DIV_W,
  parameter int Q_W = D1_Q_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIV_W-1:0]  in_rem,
  input  logic [Q_W-1:0]    in_low,
  input  logic [DIV_W-1:0]  in_div,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic [SIDE_W-1:0] out_side
);

  logic              st_valid [1:Q_W];
  logic [DIV_W-1:0]  st_rem   [1:Q_W];
  logic [Q_W-1:0]    st_low   [1:Q_W];
  logic [Q_W-1:0]    st_quot  [1:Q_W];
  logic [DIV_W-1:0]  st_div   [1:Q_W];
  logic [SIDE_W-1:0] st_side  [1:Q_W];

  // one quotient bit per stage, restoring form
  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic              a_valid;
    logic [DIV_W-1:0]  a_rem;
    logic [Q_W-1:0]    a_low;
    logic [Q_W-1:0]    a_quot;
    logic [DIV_W-1:0]  a_div;
    logic [SIDE_W-1:0] a_side;
    logic [DIV_W:0]    trial;
    logic              take;

    if (s == 0) begin : g_first
      assign a_valid = in_valid;
      assign a_rem = in_rem;
      assign a_low = in_low;
      assign a_quot = '0;
      assign a_div = in_div;
      assign a_side = in_side;
    end else begin : g_next
      assign a_valid = st_valid[s];
      assign a_rem = st_rem[s];
      assign a_low = st_low[s];
      assign a_quot = st_quot[s];
      assign a_div = st_div[s];
      assign a_side = st_side[s];
    end

    assign trial = {a_rem, a_low[Q_W-1]};
    assign take = trial >= {1'b0, a_div};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s+1] <= 1'b0;
      end else if (en) begin
        st_valid[s+1] <= a_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (take) begin
          st_rem[s+1] <= DIV_W'(trial - {1'b0, a_div});
        end else begin
          st_rem[s+1] <= trial[DIV_W-1:0];
        end
        st_low[s+1] <= a_low << 1;
        st_quot[s+1] <= {a_quot[Q_W-2:0], take};
        st_div[s+1] <= a_div;
        st_side[s+1] <= a_side;
      end
    end
  end

  assign out_valid = st_valid[Q_W];
  assign quot = st_quot[Q_W];
  assign out_side = st_side[Q_W];

endmodule

@@ rtl/rh_cordic.sv @@
module rh_cordic import rh_pkg::*; #(
  parameter int N_STAGES = ITER_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  cordic_op_t           in_op,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [CW-1:0] in_z,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic signed [CW-1:0] out_z,
  output logic [SIDE_W-1:0]    out_side
);

  logic                 st_valid [1:N_STAGES];
  cordic_op_t           st_op    [1:N_STAGES];
  logic signed [CW-1:0] st_x     [1:N_STAGES];
  logic signed [CW-1:0] st_y     [1:N_STAGES];
  logic signed [CW-1:0] st_z     [1:N_STAGES];
  logic [SIDE_W-1:0]    st_side  [1:N_STAGES];

  // one micro-rotation per stage
  for (genvar s = 0; s < N_STAGES; s++) begin : g_stage
    localparam int HSH = hyp_shift(s);
    localparam logic signed [CW-1:0] C_ANG = circ_angle(s);
    localparam logic signed [CW-1:0] H_ANG = hyp_angle(HSH);

    logic                 a_valid;
    cordic_op_t           a_op;
    logic signed [CW-1:0] a_x, a_y, a_z;
    logic [SIDE_W-1:0]    a_side;
    logic signed [CW-1:0] x_next, y_next, z_next;

    if (s == 0) begin : g_first
      assign a_valid = in_valid;
      assign a_op = in_op;
      assign a_x = in_x;
      assign a_y = in_y;
      assign a_z = in_z;
      assign a_side = in_side;
    end else begin : g_next
      assign a_valid = st_valid[s];
      assign a_op = st_op[s];
      assign a_x = st_x[s];
      assign a_y = st_y[s];
      assign a_z = st_z[s];
      assign a_side = st_side[s];
    end

    always_comb begin
      case (a_op)
        OP_VEC: begin
          if (!a_y[CW-1]) begin
            x_next = a_x + (a_y >>> s);
            y_next = a_y - (a_x >>> s);
            z_next = a_z + C_ANG;
          end else begin
            x_next = a_x - (a_y >>> s);
            y_next = a_y + (a_x >>> s);
            z_next = a_z - C_ANG;
          end
        end
        OP_ROT_H: begin
          if (!a_z[CW-1]) begin
            x_next = a_x + (a_y >>> HSH);
            y_next = a_y + (a_x >>> HSH);
            z_next = a_z - H_ANG;
          end else begin
            x_next = a_x - (a_y >>> HSH);
            y_next = a_y - (a_x >>> HSH);
            z_next = a_z + H_ANG;
          end
        end
        default: begin
          if (!a_z[CW-1]) begin
            x_next = a_x - (a_y >>> s);
            y_next = a_y + (a_x >>> s);
            z_next = a_z - C_ANG;
          end else begin
            x_next = a_x + (a_y >>> s);
            y_next = a_y - (a_x >>> s);
            z_next = a_z + C_ANG;
          end
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s+1] <= 1'b0;
      end else if (en) begin
        st_valid[s+1] <= a_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_op[s+1] <= a_op;
        st_x[s+1] <= x_next;
        st_y[s+1] <= y_next;
        st_z[s+1] <= z_next;
        st_side[s+1] <= a_side;
      end
    end
  end

  assign out_valid = st_valid[N_STAGES];
  assign out_x = st_x[N_STAGES];
  assign out_y = st_y[N_STAGES];
  assign out_z = st_z[N_STAGES];
  assign out_side = st_side[N_STAGES];

endmodule

@@ rtl/regularized_heaviside.sv @@
// Regularized Heaviside step: maps a signed Q8.8 level-set value to a
// smoothed step in signed Q2.14 (arctan, binary, sigmoid or sine-ramp shape).
// Input channel: level_valid / level_stall / level_value. Output channel:
// step_valid / step_stall / step_value. A request moves when valid is high
// and stall is low. Shape and transition width are set over the APB port
// (step_mode at 0x0, fuzziness at 0x4); the user must write them only
// while the block is idle; the block does not enforce this. Pipeline:
// input register, 40-stage divider for |v|/f, two prep stages, one stage
// per cordic iteration, two post stages, 15-stage ratio divider, output reg.
// Throughput: one request per cycle when not stalled; every stage is a
// single register step. Reset (synchronous, rst high) empties the pipeline
// and sets step_mode to arctan and fuzziness to 2.0. When the receiver
// stalls a waiting result, the whole pipeline holds and level_stall rises
// in the same cycle; no request is dropped or repeated.
module regularized_heaviside import rh_pkg::*; #(
  parameter int ITER_STAGES = ITER_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               level_valid,
  output logic               level_stall,
  input  logic signed [15:0] level_value,
  output logic               step_valid,
  input  logic               step_stall,
  output logic signed [15:0] step_value
);

  mode_t       step_mode;
  logic [15:0] fuzziness;
  logic        en;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_mode <= MODE_ATAN;
      fuzziness <= FUZZ_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_STEP_MODE: step_mode <= mode_t'(pwdata[1:0]);
        REG_FUZZINESS: fuzziness <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_STEP_MODE: prdata = {30'd0, step_mode};
      REG_FUZZINESS: prdata = {16'd0, fuzziness};
    endcase
  end

  // global advance: hold everything while a result waits
  assign en = !(step_valid && step_stall);
  assign level_stall = !en;

  // input stage
  logic               s0_valid;
  logic signed [15:0] s0_v;
  logic [15:0]        s0_f;
  mode_t              s0_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= level_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_v <= level_value;
      s0_f <= (fuzziness == 16'd0) ? 16'd1 : fuzziness;
      s0_mode <= step_mode;
    end
  end

  // magnitude and the shapes that need no arithmetic
  logic [15:0]        s0_mag;
  logic signed [16:0] v_ext, f_ext;
  logic               above, below;
  front_side_t        f_side;

  assign s0_mag = s0_v[15] ? 16'(-s0_v) : 16'(s0_v);
  assign v_ext = {s0_v[15], s0_v};
  assign f_ext = {1'b0, s0_f};
  assign above = v_ext > f_ext;
  assign below = v_ext < -f_ext;

  always_comb begin
    f_side.mode = s0_mode;
    f_side.v = s0_v;
    f_side.f = s0_f;
    case (s0_mode)
      MODE_BIN: begin
        f_side.fixed = 1'b1;
        f_side.fixed_res = (s0_v > 16'sd0) ? ONE_Q14 : 16'sd0;
      end
      MODE_SINE: begin
        f_side.fixed = above || below;
        f_side.fixed_res = above ? ONE_Q14 : 16'sd0;
      end
      default: begin
        f_side.fixed = 1'b0;
        f_side.fixed_res = 16'sd0;
      end
    endcase
  end

  // r = |v| * 2^24 / f
  logic                        d1_valid;
  logic [D1_Q_W-1:0]           d1_quot;
  logic [$bits(front_side_t)-1:0] d1_side_bits;
  front_side_t                 d1_side;

  rh_div #(
    .DIV_W (D1_DIV_W),
    .Q_W   (D1_Q_W),
    .SIDE_W($bits(front_side_t))
  ) u_div_ratio (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s0_valid),
    .in_rem   ('0),
    .in_low   ({s0_mag, 24'd0}),
    .in_div   (s0_f),
    .in_side  (f_side),
    .out_valid(d1_valid),
    .quot     (d1_quot),
    .out_side (d1_side_bits)
  );

  assign d1_side = front_side_t'(d1_side_bits);

  // prep a: octave count for the sigmoid, folded sine argument
  logic [38:0]  u;
  logic [3:0]   k_cnt;
  logic         sig_sat;
  logic [24:0]  r25;
  logic [23:0]  rr;
  front_side_t  pa_side_next;

  assign u = d1_quot[D1_Q_W-1:1];
  assign r25 = d1_quot[24:0];
  assign rr = (r25 > 25'(1 << 23)) ? 24'(25'(1 << 24) - r25) : r25[23:0];
  assign sig_sat = u >= 39'(LN2_Q24) * 39'd10;

  always_comb begin
    k_cnt = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (u >= 39'(LN2_Q24) * 39'(j)) k_cnt = k_cnt + 4'd1;
    end
  end

  always_comb begin
    pa_side_next = d1_side;
    if (d1_side.mode == MODE_SIG && sig_sat) begin
      pa_side_next.fixed = 1'b1;
      pa_side_next.fixed_res = d1_side.v[15] ? -ONE_Q14 : ONE_Q14;
    end
  end

  logic        pa_valid;
  front_side_t pa_side;
  logic [3:0]  pa_k;
  logic [26:0] pa_u27;
  logic [24:0] pa_r25;
  logic [23:0] pa_rr;

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_valid <= 1'b0;
    end else if (en) begin
      pa_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_side <= pa_side_next;
      pa_k <= k_cnt;
      pa_u27 <= u[26:0];
      pa_r25 <= r25;
      pa_rr <= rr;
    end
  end

  // prep b: cordic start vectors
  logic [26:0]          t_red;
  logic [49:0]          ang_prod;
  logic signed [CW-1:0] ang32;
  cordic_op_t           op_c;
  logic signed [CW-1:0] x_c, y_c, z_c;
  cordic_side_t         c_side;

  assign t_red = pa_u27 - (27'(pa_k) * LN2_Q24);
  assign ang_prod = 50'(pa_rr) * 50'(PI_Q24) + 50'(1 << 23);
  assign ang32 = $signed({6'd0, ang_prod[49:24]});

  always_comb begin
    case (pa_side.mode)
      MODE_ATAN: begin
        op_c = OP_VEC;
        x_c = $signed({8'd0, pa_side.f, 8'd0});
        y_c = $signed({{8{pa_side.v[15]}}, pa_side.v, 8'd0});
        z_c = '0;
      end
      MODE_SINE: begin
        op_c = OP_ROT_C;
        x_c = GAIN_Q28;
        y_c = '0;
        z_c = pa_side.v[15] ? -ang32 : ang32;
      end
      MODE_SIG: begin
        op_c = OP_ROT_H;
        x_c = CW'(1 << 28);
        y_c = '0;
        z_c = $signed({5'd0, t_red});
      end
      default: begin
        op_c = OP_ROT_C;
        x_c = '0;
        y_c = '0;
        z_c = '0;
      end
    endcase
    c_side.mode = pa_side.mode;
    c_side.neg = pa_side.v[15];
    c_side.fixed = pa_side.fixed;
    c_side.fixed_res = pa_side.fixed_res;
    c_side.r25 = pa_r25;
    c_side.k = pa_k;
  end

  logic                 pb_valid;
  cordic_op_t           pb_op;
  logic signed [CW-1:0] pb_x, pb_y, pb_z;
  cordic_side_t         pb_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      pb_valid <= 1'b0;
    end else if (en) begin
      pb_valid <= pa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb_op <= op_c;
      pb_x <= x_c;
      pb_y <= y_c;
      pb_z <= z_c;
      pb_side <= c_side;
    end
  end

  // cordic iterations
  logic                            co_valid;
  logic signed [CW-1:0]            co_x, co_y, co_z;
  logic [$bits(cordic_side_t)-1:0] co_side_bits;
  cordic_side_t                    co_side;

  rh_cordic #(
    .N_STAGES(ITER_STAGES),
    .SIDE_W  ($bits(cordic_side_t))
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pb_valid),
    .in_op    (pb_op),
    .in_x     (pb_x),
    .in_y     (pb_y),
    .in_z     (pb_z),
    .in_side  (pb_side),
    .out_valid(co_valid),
    .out_x    (co_x),
    .out_y    (co_y),
    .out_z    (co_z),
    .out_side (co_side_bits)
  );

  assign co_side = cordic_side_t'(co_side_bits);

  // post 1: scale by 1/pi, sum and difference for the sigmoid
  logic signed [CW:0]   z_ext, y_ext, mul_a;
  logic signed [63:0]   prod_c;

  assign z_ext = {co_z[CW-1], co_z};
  assign y_ext = {co_y[CW-1], co_y};
  assign mul_a = (co_side.mode == MODE_ATAN) ? (co_z[CW-1] ? -z_ext : z_ext) : y_ext;
  assign prod_c = 64'(mul_a) * 64'(INVPI_Q30);

  logic               p1_valid;
  logic signed [63:0] p1_prod;
  logic [CW-1:0]      p1_p, p1_m;
  logic               p1_zneg;
  cordic_side_t       p1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= co_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_prod <= prod_c;
      p1_p <= CW'(co_x + co_y);
      p1_m <= CW'(co_x - co_y);
      p1_zneg <= co_z[CW-1];
      p1_side <= co_side;
    end
  end

  // post 2: finish arctan and sine, set up the sigmoid ratio
  logic signed [63:0]   q_wide, sp_wide;
  logic signed [CW-1:0] q_at, atan_val, sp, rq, sine_sum, sine_rnd;
  logic signed [15:0]   sine_res;
  logic [49:0]          big, num, den;
  logic [63:0]          dividend;
  tail_side_t           t_side;

  assign q_wide = (p1_prod + 64'sd549755813888) >>> 40;
  assign q_at = q_wide[CW-1:0];
  assign atan_val = 32'sd8192 + (p1_zneg ? -q_at : q_at);

  assign sp_wide = p1_prod >>> 30;
  assign sp = sp_wide[CW-1:0];
  assign rq = $signed({3'd0, p1_side.r25, 4'd0});
  assign sine_sum = CW'(1 << 28) + (p1_side.neg ? -rq : rq) + sp;
  assign sine_rnd = (sine_sum + 32'sd16384) >>> 15;
  assign sine_res = sine_sum[CW-1] ? 16'sd0 : clamp_q14(sine_rnd);

  assign big = 50'(p1_p) << (5'(p1_side.k) << 1);
  assign num = big - 50'(p1_m);
  assign den = big + 50'(p1_m);
  assign dividend = {num[49:0], 14'd0} + 64'(den >> 1);

  always_comb begin
    t_side.neg = p1_side.neg;
    t_side.use_quot = 1'b0;
    if (p1_side.fixed) begin
      t_side.res = p1_side.fixed_res;
    end else begin
      case (p1_side.mode)
        MODE_ATAN: t_side.res = clamp_q14(atan_val);
        MODE_SINE: t_side.res = sine_res;
        MODE_SIG: begin
          t_side.res = 16'sd0;
          t_side.use_quot = 1'b1;
        end
        default: t_side.res = 16'sd0;
      endcase
    end
  end

  logic                 p2_valid;
  logic [D2_DIV_W-1:0]  p2_rem;
  logic [D2_Q_W-1:0]    p2_low;
  logic [D2_DIV_W-1:0]  p2_den;
  tail_side_t           p2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_rem <= D2_DIV_W'(dividend[63:D2_Q_W]);
      p2_low <= dividend[D2_Q_W-1:0];
      p2_den <= den;
      p2_side <= t_side;
    end
  end

  // rounded sigmoid ratio
  logic                          d2_valid;
  logic [D2_Q_W-1:0]             d2_quot;
  logic [$bits(tail_side_t)-1:0] d2_side_bits;
  tail_side_t                    d2_side;
  logic signed [15:0]            q16;

  rh_div #(
    .DIV_W (D2_DIV_W),
    .Q_W   (D2_Q_W),
    .SIDE_W($bits(tail_side_t))
  ) u_div_sig (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p2_valid),
    .in_rem   (p2_rem),
    .in_low   (p2_low),
    .in_div   (p2_den),
    .in_side  (p2_side),
    .out_valid(d2_valid),
    .quot     (d2_quot),
    .out_side (d2_side_bits)
  );

  assign d2_side = tail_side_t'(d2_side_bits);
  assign q16 = $signed({1'b0, d2_quot});

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else if (en) begin
      step_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d2_side.use_quot) begin
        step_value <= d2_side.neg ? -q16 : q16;
      end else begin
        step_value <= d2_side.res;
      end
    end
  end

  // input is held back only while a result waits at the output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    level_stall |-> (step_valid && step_stall))
    else $error("input stalled without a waiting result");

  // results stay within -1..1
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    step_valid |-> (step_value <= ONE_Q14 && step_value >= -ONE_Q14))
    else $error("step result out of range");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !step_valid)
    else $error("result valid after reset");

endmodule
